### rtl/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg
// shared types and constants of the command line tokenizer
// ----------------------------------------------------------------------------
package clt_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;

  // special characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam logic [7:0] MAX_TOKENS_RST = 8'd16;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] token_index;
    logic [7:0] token_total;
    logic       unterminated;
    logic       last;
  } result_t;

endpackage

### rtl/clt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt channel interfaces
// valid/ready channels for the input bytes, the results and the register
// ----------------------------------------------------------------------------
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [7:0] token_index;
  logic [7:0] token_total;
  logic       unterminated;
  logic       last;

  modport source (output valid, output kind, output out_byte, output token_index,
                  output token_total, output unterminated, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input token_index,
                  input token_total, input unterminated, input last, output ready);
endinterface

interface clt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_tokens;

  modport source (output valid, output max_tokens, input ready);
  modport sink   (input valid, input max_tokens, output ready);
endinterface

### rtl/command_line_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// splits a zero-terminated command line into shell-style arguments, one
// byte per request, emitting argument bytes, argument ends and a line summary
// ----------------------------------------------------------------------------
//
// channel   dir  payload                                      request when
// in_chan   in   ch                                           valid & ready
// out_chan  out  kind, out_byte, token_index, token_total,    valid & ready
//                unterminated, last
// cfg_chan  in   max_tokens                                   valid & ready
//
// one input byte is taken per cycle; its results are written into the result
// queue at the accepting edge and the head shows on out_chan the cycle after
// the end of line byte may push two results (argument end, line summary), so
// in_chan.ready is high while the queue has at least two free slots
// with out_chan always ready each two-result end of line leaves one extra
// entry and each byte that pushes nothing drains one; input stalls only while
// three entries wait, and output stalls fill the queue and stop input
// rst_n is synchronous: parser state cleared, queue emptied, max_tokens = 16
// cfg_chan is always ready and takes effect on the next input byte
// ----------------------------------------------------------------------------
module command_line_tokenizer_unit #(
  parameter int OUT_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  clt_in_if.sink       in_chan,
  clt_out_if.source    out_chan,
  clt_cfg_if.sink      cfg_chan
);

  localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  // configuration register
  logic [7:0] max_tokens_r;

  // parser state
  logic       in_token_r, in_token_nxt;
  logic       escape_r, escape_nxt;
  logic       in_quote_r, in_quote_nxt;
  logic       quote_dbl_r, quote_dbl_nxt;
  logic [7:0] tok_cnt_r, tok_cnt_nxt;

  // result queue
  clt_pkg::result_t mem_r [OUT_DEPTH];
  logic [PTR_W-1:0] head_r, tail_r, tail_p1;
  logic [CNT_W-1:0] count_r;

  // per-byte results
  clt_pkg::result_t res0, res1;
  logic [1:0]       push_n;
  logic             accept, pop, active;
  logic [7:0]       ch;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(OUT_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign ch     = in_chan.ch;
  assign accept = in_chan.valid && in_chan.ready;
  assign pop    = out_chan.valid && out_chan.ready;
  assign active = tok_cnt_r < max_tokens_r;

  // room for the two results of an end of line
  assign in_chan.ready  = count_r <= CNT_W'(OUT_DEPTH - 2);
  assign cfg_chan.ready = 1'b1;

  // ---------------------------------------------------------------------------
  // byte parser: all decisions for one byte in one pass
  // ---------------------------------------------------------------------------
  always_comb begin
    in_token_nxt  = in_token_r;
    escape_nxt    = escape_r;
    in_quote_nxt  = in_quote_r;
    quote_dbl_nxt = quote_dbl_r;
    tok_cnt_nxt   = tok_cnt_r;
    res0          = '0;
    res1          = '0;
    push_n        = 2'd0;

    if (ch == clt_pkg::CH_NUL) begin
      // end of line: close a clean argument, report, clear the line
      res1.kind = clt_pkg::KIND_LINE;
      res1.last = 1'b1;
      if (active && (escape_r || in_quote_r)) begin
        // open quote or pending escape drops the argument
        res1.unterminated = 1'b1;
      end
      if (active && in_token_r && !escape_r && !in_quote_r) begin
        res0.kind        = clt_pkg::KIND_END;
        res0.token_index = tok_cnt_r;
        res1.token_total = tok_cnt_r + 8'd1;
        push_n           = 2'd2;
      end else begin
        res1.token_total = tok_cnt_r;
        res0             = res1;
        push_n           = 2'd1;
      end
      in_token_nxt  = 1'b0;
      escape_nxt    = 1'b0;
      in_quote_nxt  = 1'b0;
      quote_dbl_nxt = 1'b0;
      tok_cnt_nxt   = '0;
    end else if (active) begin
      // byte result template, used where a byte goes out
      res0.kind        = clt_pkg::KIND_BYTE;
      res0.out_byte    = ch;
      res0.token_index = tok_cnt_r;
      res0.last        = 1'b1;
      if (escape_r) begin
        escape_nxt = 1'b0;
        push_n     = 2'd1;
      end else if (in_quote_r) begin
        if (ch == (quote_dbl_r ? clt_pkg::CH_DQUOTE : clt_pkg::CH_SQUOTE)) begin
          in_quote_nxt = 1'b0;
        end else begin
          push_n = 2'd1;
        end
      end else if (ch == clt_pkg::CH_BSLASH) begin
        escape_nxt   = 1'b1;
        in_token_nxt = 1'b1;
      end else if (ch == clt_pkg::CH_SPACE) begin
        // only the first space after an argument ends it
        if (in_token_r) begin
          res0.kind     = clt_pkg::KIND_END;
          res0.out_byte = '0;
          push_n        = 2'd1;
          tok_cnt_nxt   = tok_cnt_r + 8'd1;
          in_token_nxt  = 1'b0;
        end
      end else if (ch == clt_pkg::CH_SQUOTE || ch == clt_pkg::CH_DQUOTE) begin
        in_quote_nxt  = 1'b1;
        quote_dbl_nxt = (ch == clt_pkg::CH_DQUOTE);
        in_token_nxt  = 1'b1;
      end else begin
        in_token_nxt = 1'b1;
        push_n       = 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // state and configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tokens_r <= clt_pkg::MAX_TOKENS_RST;
      in_token_r   <= 1'b0;
      escape_r     <= 1'b0;
      in_quote_r   <= 1'b0;
      quote_dbl_r  <= 1'b0;
      tok_cnt_r    <= '0;
    end else begin
      if (cfg_chan.valid) begin
        max_tokens_r <= cfg_chan.max_tokens;
      end
      if (accept) begin
        in_token_r  <= in_token_nxt;
        escape_r    <= escape_nxt;
        in_quote_r  <= in_quote_nxt;
        quote_dbl_r <= quote_dbl_nxt;
        tok_cnt_r   <= tok_cnt_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result queue: up to two writes, one read per cycle
  // ---------------------------------------------------------------------------
  logic [1:0] push_eff;

  assign tail_p1  = ptr_inc(tail_r);
  assign push_eff = accept ? push_n : 2'd0;

  always_ff @(posedge clk) begin
    if (push_eff != 2'd0) begin
      mem_r[tail_r] <= res0;
    end
    if (push_eff == 2'd2) begin
      mem_r[tail_p1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (pop) begin
        head_r <= ptr_inc(head_r);
      end
      if (push_eff == 2'd1) begin
        tail_r <= tail_p1;
      end else if (push_eff == 2'd2) begin
        tail_r <= ptr_inc(tail_p1);
      end
      count_r <= count_r + CNT_W'(push_eff) - CNT_W'(pop);
    end
  end

  assign out_chan.valid        = count_r != '0;
  assign out_chan.kind         = mem_r[head_r].kind;
  assign out_chan.out_byte     = mem_r[head_r].out_byte;
  assign out_chan.token_index  = mem_r[head_r].token_index;
  assign out_chan.token_total  = mem_r[head_r].token_total;
  assign out_chan.unterminated = mem_r[head_r].unterminated;
  assign out_chan.last         = mem_r[head_r].last;

endmodule
